// ===== rtl/tfp_pkg.sv =====
`timescale 1ns / 1ps

package tfp_pkg;

   // Load cell: weight = (raw - 205) * 50000 / 818, done as a multiply by a
   // rounded-up Q16 reciprocal that is exact over the 10-bit range.
   localparam logic [9:0]  RAW_ZERO   = 10'd205;
   localparam logic [21:0] WEIGHT_MUL = 22'd4005868;
   // Well volume in Q16: 1.4687965402597 * 8.34
   localparam logic [19:0] WELL_K_Q16 = 20'd802800;
   // Fill seconds = target * 20 / 139, rounded-up reciprocal in Q24
   localparam logic [21:0] SECS_MUL   = 22'd2413988;
   // Fill time = secs * 6 / 5, rounded-up reciprocal in Q16
   localparam logic [16:0] TIME_MUL   = 17'd78644;

   // Register index, byte address is 4 * index; the last index maps to nothing
   typedef enum logic [2:0] {
      REG_MAX_WEIGHT,
      REG_HYSTERESIS,
      REG_MAX_INCREMENT,
      REG_HOUSE_MIN,
      REG_WORKING_DEPTH,
      REG_SAFETY_DEPTH,
      REG_RECHARGE_TIME,
      REG_UNUSED
   } tfp_reg_type;

   typedef struct packed {
      logic [15:0] max_weight;
      logic [13:0] hysteresis;
      logic [15:0] max_increment;
      logic [15:0] house_pump_min_weight;
      logic [13:0] well_working_depth;
      logic [13:0] well_safety_depth;
      logic [15:0] recharge_time;
   } tfp_cfg_type;

   // One step enable per sequencer state
   typedef struct packed {
      logic load;
      logic mul;
      logic decide;
      logic mul_secs;
      logic mul_time;
      logic finish;
   } tfp_cmd_type;

endpackage

// ===== rtl/tfp_ctrl.sv =====
`timescale 1ns / 1ps

module tfp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tfp_pkg::tfp_cmd_type cmd
);
   import tfp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DECIDE,
      ST_MUL_SECS,
      ST_MUL_TIME,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.load     = req_valid && (state_ff == ST_IDLE);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.decide   = (state_ff == ST_DECIDE);
      cmd.mul_secs = (state_ff == ST_MUL_SECS);
      cmd.mul_time = (state_ff == ST_MUL_TIME);
      cmd.finish   = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_MUL;
            end
            ST_MUL:      state_ff <= ST_DECIDE;
            ST_DECIDE:   state_ff <= ST_MUL_SECS;
            ST_MUL_SECS: state_ff <= ST_MUL_TIME;
            ST_MUL_TIME: state_ff <= ST_FINISH;
            ST_FINISH: begin
               // hold until the output register is free
               if (out_free) state_ff <= ST_IDLE;
            end
            default:     state_ff <= ST_IDLE;
         endcase
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_MUL)
      else $error("accepted request did not start the sequence");
   a_mul_to_decide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == ST_DECIDE)
      else $error("sequence skipped the decide step");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished request not presented");
`endif

endmodule

// ===== rtl/tfp_datapath.sv =====
`timescale 1ns / 1ps

module tfp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tfp_pkg::tfp_cmd_type cmd,
   input  tfp_pkg::tfp_cfg_type cfg,
   input  logic [15:0]          req_now_time,
   input  logic [9:0]           req_scale_raw,
   input  logic [13:0]          req_well_depth,
   input  logic [15:0]          req_well_valid_until,
   output logic [15:0]          rsp_tank_weight,
   output logic                 rsp_fill_valve_open,
   output logic                 rsp_fill_stopped,
   output logic                 rsp_fill_started,
   output logic [3:0]           rsp_stop_reasons,
   output logic                 rsp_house_pump_on,
   output logic                 rsp_well_pump_on
);
   import tfp_pkg::*;

   function automatic logic ended(input logic [15:0] now, input logic [15:0] deadline);
      logic [15:0] diff;
      diff = now - deadline;
      return !diff[15];
   endfunction

   // latched request
   logic [15:0] now_ff;
   logic [9:0]  raw_ff;
   logic [13:0] depth_ff;
   logic [15:0] valid_until_ff;

   // controller state
   logic        valve_ff;
   logic        house_ff;
   logic        well_ff;
   logic [15:0] goal_ff;
   logic [15:0] fill_deadline_ff;
   logic [15:0] recharge_ff;

   // products and per-request results
   logic [31:0] wprod_ff;
   logic [33:0] aprod_ff;
   logic [37:0] sprod_ff;
   logic [30:0] tprod_ff;
   logic [15:0] target_ff;
   logic [3:0]  reasons_ff;
   logic        stopped_ff;
   logic        started_ff;

   // output register
   logic [15:0] weight_out_ff;
   logic        valve_out_ff;
   logic        stopped_out_ff;
   logic        started_out_ff;
   logic [3:0]  reasons_out_ff;
   logic        house_out_ff;
   logic        well_out_ff;

   logic [9:0]  raw_delta;
   logic [13:0] depth_short;
   logic [15:0] weight;
   logic [15:0] avail;
   logic [15:0] space;
   logic [15:0] target;
   logic [16:0] goal_sum;
   logic [3:0]  reasons;
   logic        at_working;
   logic        current;
   logic        stop;
   logic        valve_mid;
   logic        start;
   logic [15:0] recharge_in;
   logic        house_in;
   logic        well_in;
   logic        hold;
   logic [13:0] secs;
   logic [14:0] fill_time;

   assign raw_delta   = (raw_ff >= RAW_ZERO) ? (raw_ff - RAW_ZERO) : 10'd0;
   assign depth_short = (cfg.well_working_depth > depth_ff)
                        ? (cfg.well_working_depth - depth_ff) : 14'd0;

   assign weight = wprod_ff[31:16];
   assign avail  = (|aprod_ff[33:32]) ? 16'hFFFF : aprod_ff[31:16];
   assign space  = (cfg.max_weight > weight) ? (cfg.max_weight - weight) : 16'd0;

   always_comb begin
      target = space;
      if (avail < target) target = avail;
      if (cfg.max_increment < target) target = cfg.max_increment;
   end

   assign goal_sum   = {1'b0, weight} + {1'b0, target};
   assign at_working = (depth_ff >= cfg.well_working_depth);
   assign current    = !ended(now_ff, valid_until_ff);

   assign reasons[0] = (weight >= cfg.max_weight);
   assign reasons[1] = at_working;
   assign reasons[2] = valve_ff && ended(now_ff, fill_deadline_ff);
   assign reasons[3] = (weight >= goal_ff);

   assign stop        = valve_ff && (|reasons);
   assign recharge_in = stop ? (now_ff + cfg.recharge_time) : recharge_ff;
   assign valve_mid   = valve_ff && !stop;
   assign start       = !valve_mid
                        && (({1'b0, weight} + {1'b0, cfg.max_increment})
                            < {1'b0, cfg.max_weight})
                        && !at_working
                        && ended(now_ff, recharge_in)
                        && current;

   always_comb begin
      house_in = house_ff;
      if (house_ff && (weight <= cfg.house_pump_min_weight)) begin
         house_in = 1'b0;
      end else if (!house_ff && ({1'b0, weight} >
               ({1'b0, cfg.house_pump_min_weight} + {3'b000, cfg.hysteresis}))) begin
         house_in = 1'b1;
      end
   end

   assign hold = ({1'b0, weight} >= ({1'b0, cfg.max_weight} + {3'b000, cfg.hysteresis}))
                 || (depth_ff >= cfg.well_safety_depth);

   always_comb begin
      well_in = well_ff;
      if (hold && well_ff) begin
         well_in = 1'b0;
      end else if (!hold && current && !well_ff) begin
         well_in = 1'b1;
      end
   end

   assign secs      = sprod_ff[37:24];
   assign fill_time = tprod_ff[30:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         valve_ff         <= 1'b0;
         house_ff         <= 1'b0;
         well_ff          <= 1'b0;
         goal_ff          <= 16'd0;
         fill_deadline_ff <= 16'd0;
         recharge_ff      <= 16'd0;
      end else begin
         if (cmd.decide) begin
            valve_ff    <= valve_mid || start;
            recharge_ff <= recharge_in;
            house_ff    <= house_in;
            well_ff     <= well_in;
            if (start) goal_ff <= goal_sum[16] ? 16'hFFFF : goal_sum[15:0];
         end
         if (cmd.finish && started_ff) begin
            fill_deadline_ff <= now_ff + {1'b0, fill_time};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff         <= req_now_time;
         raw_ff         <= req_scale_raw;
         depth_ff       <= req_well_depth;
         valid_until_ff <= req_well_valid_until;
      end
      if (cmd.mul) begin
         wprod_ff <= raw_delta * WEIGHT_MUL;
         aprod_ff <= depth_short * WELL_K_Q16;
      end
      if (cmd.decide) begin
         target_ff  <= target;
         reasons_ff <= reasons;
         stopped_ff <= stop;
         started_ff <= start;
      end
      if (cmd.mul_secs) sprod_ff <= target_ff * SECS_MUL;
      if (cmd.mul_time) tprod_ff <= secs * TIME_MUL;
      if (cmd.finish) begin
         weight_out_ff  <= weight;
         valve_out_ff   <= valve_ff;
         stopped_out_ff <= stopped_ff;
         started_out_ff <= started_ff;
         reasons_out_ff <= reasons_ff;
         house_out_ff   <= house_ff;
         well_out_ff    <= well_ff;
      end
   end

   assign rsp_tank_weight     = weight_out_ff;
   assign rsp_fill_valve_open = valve_out_ff;
   assign rsp_fill_stopped    = stopped_out_ff;
   assign rsp_fill_started    = started_out_ff;
   assign rsp_stop_reasons    = reasons_out_ff;
   assign rsp_house_pump_on   = house_out_ff;
   assign rsp_well_pump_on    = well_out_ff;

endmodule

// ===== rtl/tank_fill_and_pump_controller_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Contents
// req       in         req_valid/req_stall   tick time, raw scale, well depth, expiry
// rsp       out        rsp_valid/rsp_stall   weight, valve, stop/start, reasons, pumps
// csr       in/out     psel/penable/pready   seven config registers at 4*index
//
// A request holds the sequencer through the accepting cycle, four fixed
// steps (weight and well multiply, decide, two fill-time multiplies) and the
// result load, which registers the result and raises rsp_valid.
// Reset is synchronous; no clearing pass. A new request is taken while an earlier
// result waits; a stalled result holds the sequencer in its last step.
module tank_fill_and_pump_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_now_time,
   input  logic [9:0]  req_scale_raw,
   input  logic [13:0] req_well_depth,
   input  logic [15:0] req_well_valid_until,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_tank_weight,
   output logic        rsp_fill_valve_open,
   output logic        rsp_fill_stopped,
   output logic        rsp_fill_started,
   output logic [3:0]  rsp_stop_reasons,
   output logic        rsp_house_pump_on,
   output logic        rsp_well_pump_on,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tfp_pkg::*;

   tfp_cfg_type cfg_ff;
   tfp_cmd_type cmd;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_weight            <= 16'd40000;
         cfg_ff.hysteresis            <= 14'd500;
         cfg_ff.max_increment         <= 16'd5000;
         cfg_ff.house_pump_min_weight <= 16'd2000;
         cfg_ff.well_working_depth    <= 14'd1500;
         cfg_ff.well_safety_depth     <= 14'd1800;
         cfg_ff.recharge_time         <= 16'd600;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAX_WEIGHT:    cfg_ff.max_weight            <= csr_pwdata[15:0];
            REG_HYSTERESIS:    cfg_ff.hysteresis            <= csr_pwdata[13:0];
            REG_MAX_INCREMENT: cfg_ff.max_increment         <= csr_pwdata[15:0];
            REG_HOUSE_MIN:     cfg_ff.house_pump_min_weight <= csr_pwdata[15:0];
            REG_WORKING_DEPTH: cfg_ff.well_working_depth    <= csr_pwdata[13:0];
            REG_SAFETY_DEPTH:  cfg_ff.well_safety_depth     <= csr_pwdata[13:0];
            REG_RECHARGE_TIME: cfg_ff.recharge_time         <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MAX_WEIGHT:    csr_prdata = {16'd0, cfg_ff.max_weight};
         REG_HYSTERESIS:    csr_prdata = {18'd0, cfg_ff.hysteresis};
         REG_MAX_INCREMENT: csr_prdata = {16'd0, cfg_ff.max_increment};
         REG_HOUSE_MIN:     csr_prdata = {16'd0, cfg_ff.house_pump_min_weight};
         REG_WORKING_DEPTH: csr_prdata = {18'd0, cfg_ff.well_working_depth};
         REG_SAFETY_DEPTH:  csr_prdata = {18'd0, cfg_ff.well_safety_depth};
         REG_RECHARGE_TIME: csr_prdata = {16'd0, cfg_ff.recharge_time};
         default:           csr_prdata = 32'd0;
      endcase
   end

   tfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tfp_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .cfg                  (cfg_ff),
      .req_now_time         (req_now_time),
      .req_scale_raw        (req_scale_raw),
      .req_well_depth       (req_well_depth),
      .req_well_valid_until (req_well_valid_until),
      .rsp_tank_weight      (rsp_tank_weight),
      .rsp_fill_valve_open  (rsp_fill_valve_open),
      .rsp_fill_stopped     (rsp_fill_stopped),
      .rsp_fill_started     (rsp_fill_started),
      .rsp_stop_reasons     (rsp_stop_reasons),
      .rsp_house_pump_on    (rsp_house_pump_on),
      .rsp_well_pump_on     (rsp_well_pump_on)
   );

endmodule

// ===== verif/tb_tank_fill_and_pump_controller_core.sv =====
`timescale 1ns / 1ps

module tb_tank_fill_and_pump_controller_core;
   import tfp_pkg::*;

   localparam logic [3:0] STOP_FULL    = 4'b0001;
   localparam logic [3:0] STOP_WELL    = 4'b0010;
   localparam logic [3:0] STOP_TIMEOUT = 4'b0100;
   localparam logic [3:0] STOP_TARGET  = 4'b1000;

   localparam int RAW_EMPTY      = 205;
   localparam int RAW_TOP        = 1023;
   localparam int FULL_SCALE     = 50000;
   localparam longint WELL_GAIN  = 802800;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_PHASES     = 7;
   localparam int PHASE_ITEMS    = 250;
   localparam int DRAIN_CYCLES   = 20;
   localparam int NUM_DIRECTED   = 17;

   typedef struct packed {
      logic [15:0] tank_weight;
      logic        fill_valve_open;
      logic        fill_stopped;
      logic        fill_started;
      logic [3:0]  stop_reasons;
      logic        house_pump_on;
      logic        well_pump_on;
   } tank_status_type;

   typedef struct packed {
      logic [15:0]     now_time;
      logic [9:0]      scale_raw;
      logic [13:0]     well_depth;
      logic [15:0]     well_valid_until;
      logic            known;
      tank_status_type status;
   } tick_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_now_time = '0;
   logic [9:0]  req_scale_raw = '0;
   logic [13:0] req_well_depth = '0;
   logic [15:0] req_well_valid_until = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_tank_weight;
   logic        rsp_fill_valve_open;
   logic        rsp_fill_stopped;
   logic        rsp_fill_started;
   logic [3:0]  rsp_stop_reasons;
   logic        rsp_house_pump_on;
   logic        rsp_well_pump_on;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // typed-in status travels with the request so the monitor can pick it up
   logic            tick_known = 1'b0;
   tank_status_type tick_status = '0;

   bit quiet = 1'b0;
   int mismatches = 0;
   tank_status_type awaited_status[$];

   // shadow of the controller
   tfp_cfg_type shadow_cfg;
   logic        sh_valve, sh_house, sh_well;
   logic [15:0] sh_fill_goal, sh_fill_deadline, sh_recharge_deadline;

   tank_fill_and_pump_controller_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_now_time         (req_now_time),
      .req_scale_raw        (req_scale_raw),
      .req_well_depth       (req_well_depth),
      .req_well_valid_until (req_well_valid_until),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_tank_weight      (rsp_tank_weight),
      .rsp_fill_valve_open  (rsp_fill_valve_open),
      .rsp_fill_stopped     (rsp_fill_stopped),
      .rsp_fill_started     (rsp_fill_started),
      .rsp_stop_reasons     (rsp_stop_reasons),
      .rsp_house_pump_on    (rsp_house_pump_on),
      .rsp_well_pump_on     (rsp_well_pump_on),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic deadline_passed(logic [15:0] now, logic [15:0] deadline);
      logic [15:0] diff;
      diff = now - deadline;
      return !diff[15];
   endfunction

   task automatic tank_control_step(input logic [15:0] now, input logic [9:0] raw,
                                    input logic [13:0] depth, input logic [15:0] valid_until,
                                    output tank_status_type st);
      int     weight, max_w, hyst, incr, house_min, space, avail, target, secs, goal;
      longint well_vol;
      logic   current, at_working, hold;
      st = '0;
      max_w = int'(shadow_cfg.max_weight);
      hyst = int'(shadow_cfg.hysteresis);
      incr = int'(shadow_cfg.max_increment);
      house_min = int'(shadow_cfg.house_pump_min_weight);
      weight = (int'(raw) >= RAW_EMPTY) ?
               (int'(raw) - RAW_EMPTY) * FULL_SCALE / (RAW_TOP - RAW_EMPTY) : 0;
      current = !deadline_passed(now, valid_until);
      at_working = depth >= shadow_cfg.well_working_depth;

      // stop conditions are reported on every tick
      if (weight >= max_w) st.stop_reasons |= STOP_FULL;
      if (at_working) st.stop_reasons |= STOP_WELL;
      if (sh_valve && deadline_passed(now, sh_fill_deadline)) st.stop_reasons |= STOP_TIMEOUT;
      if (weight >= int'(sh_fill_goal)) st.stop_reasons |= STOP_TARGET;
      if (st.stop_reasons != 4'b0000 && sh_valve) begin
         sh_valve = 1'b0;
         sh_recharge_deadline = now + shadow_cfg.recharge_time;
         st.fill_stopped = 1'b1;
      end

      if (!sh_valve && weight + incr < max_w && !at_working &&
          deadline_passed(now, sh_recharge_deadline) && current) begin
         space = (max_w > weight) ? max_w - weight : 0;
         avail = 0;
         if (shadow_cfg.well_working_depth > depth) begin
            well_vol = ((longint'(shadow_cfg.well_working_depth) - longint'(depth))
                        * WELL_GAIN) >>> 16;
            avail = (well_vol > 65535) ? 65535 : int'(well_vol);
         end
         target = (space < avail) ? space : avail;
         if (incr < target) target = incr;
         goal = weight + target;
         sh_fill_goal = (goal > 65535) ? 16'hFFFF : 16'(goal);
         secs = target * 20 / 139;
         sh_fill_deadline = now + 16'(secs * 6 / 5);
         sh_valve = 1'b1;
         st.fill_started = 1'b1;
      end

      if (sh_house && weight <= house_min)
         sh_house = 1'b0;
      else if (!sh_house && weight > house_min + hyst)
         sh_house = 1'b1;

      hold = (weight >= max_w + hyst) || (depth >= shadow_cfg.well_safety_depth);
      if (hold && sh_well)
         sh_well = 1'b0;
      else if (!hold && current && !sh_well)
         sh_well = 1'b1;

      st.tank_weight = 16'(weight);
      st.fill_valve_open = sh_valve;
      st.house_pump_on = sh_house;
      st.well_pump_on = sh_well;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // predict on every accepted request, compare every accepted result
   always @(posedge clock) begin
      tank_status_type predicted, want;
      if (reset) begin
         shadow_cfg <= '{16'd40000, 14'd500, 16'd5000, 16'd2000, 14'd1500, 14'd1800, 16'd600};
         sh_valve <= 1'b0;
         sh_house <= 1'b0;
         sh_well <= 1'b0;
         sh_fill_goal <= '0;
         sh_fill_deadline <= '0;
         sh_recharge_deadline <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            tank_control_step(req_now_time, req_scale_raw, req_well_depth,
                              req_well_valid_until, predicted);
            awaited_status.push_back(tick_known ? tick_status : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               mismatches++;
               $display("%0t: result with no pending request, weight %0d",
                        $time, rsp_tank_weight);
            end else begin
               want = awaited_status.pop_front();
               check_field("tank_weight", want.tank_weight, rsp_tank_weight);
               check_field("fill_valve_open", want.fill_valve_open, rsp_fill_valve_open);
               check_field("fill_stopped", want.fill_stopped, rsp_fill_stopped);
               check_field("fill_started", want.fill_started, rsp_fill_started);
               check_field("stop_reasons", want.stop_reasons, rsp_stop_reasons);
               check_field("house_pump_on", want.house_pump_on, rsp_house_pump_on);
               check_field("well_pump_on", want.well_pump_on, rsp_well_pump_on);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 22);
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_tank_fill_and_pump_controller_core NOT OK");
      $finish;
   end

   task automatic csr_write(input tfp_reg_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(int'(idx) * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_MAX_WEIGHT:    shadow_cfg.max_weight = value[15:0];
         REG_HYSTERESIS:    shadow_cfg.hysteresis = value[13:0];
         REG_MAX_INCREMENT: shadow_cfg.max_increment = value[15:0];
         REG_HOUSE_MIN:     shadow_cfg.house_pump_min_weight = value[15:0];
         REG_WORKING_DEPTH: shadow_cfg.well_working_depth = value[13:0];
         REG_SAFETY_DEPTH:  shadow_cfg.well_safety_depth = value[13:0];
         REG_RECHARGE_TIME: shadow_cfg.recharge_time = value[15:0];
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_tick(input logic [15:0] now, input logic [9:0] raw,
                            input logic [13:0] depth, input logic [15:0] valid_until,
                            input logic known, input tank_status_type status);
      while (!quiet && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_time <= now;
      req_scale_raw <= raw;
      req_well_depth <= depth;
      req_well_valid_until <= valid_until;
      tick_known <= known;
      tick_status <= status;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      tick_row_type dir_tab [NUM_DIRECTED];
      logic [31:0]  cfg_vals [7];
      logic [15:0]  plant_now, t_now, t_valid;
      logic [9:0]   t_raw;
      logic [13:0]  t_depth;
      int           plant_raw, plant_depth, step, pick;
      bit           raw_up, depth_up;

      // after reset the fill goal is zero, so the target bit is always set
      dir_tab[0]  = '{16'd0, 10'd0, 14'd0, 16'd0, 1'b1,
                      '{16'd0, 1'b0, 1'b0, 1'b0, STOP_TARGET, 1'b0, 1'b0}};
      dir_tab[1]  = '{16'd0, 10'd1023, 14'd10000, 16'd0, 1'b1,
                      '{16'd50000, 1'b0, 1'b0, 1'b0, STOP_FULL | STOP_WELL | STOP_TARGET,
                        1'b1, 1'b0}};
      dir_tab[2]  = '{16'd0, 10'd205, 14'd0, 16'd0, 1'b1,
                      '{16'd0, 1'b0, 1'b0, 1'b0, STOP_TARGET, 1'b0, 1'b0}};
      dir_tab[3]  = '{16'd1, 10'd204, 14'd16383, 16'd0, 1'b0, '0};
      // start, then stop on the fill target
      dir_tab[4]  = '{16'd100, 10'd300, 14'd0, 16'd200, 1'b0, '0};
      dir_tab[5]  = '{16'd110, 10'd400, 14'd100, 16'd300, 1'b0, '0};
      // restart after recharge, then run out the fill deadline
      dir_tab[6]  = '{16'd800, 10'd300, 14'd0, 16'd900, 1'b0, '0};
      dir_tab[7]  = '{16'd1700, 10'd350, 14'd0, 16'd1800, 1'b0, '0};
      // restart, then stop on the well reaching working depth
      dir_tab[8]  = '{16'd2400, 10'd300, 14'd0, 16'd2500, 1'b0, '0};
      dir_tab[9]  = '{16'd2410, 10'd320, 14'd1500, 16'd2500, 1'b0, '0};
      // restart, then a full tank with the well at safety depth
      dir_tab[10] = '{16'd3100, 10'd300, 14'd0, 16'd3200, 1'b0, '0};
      dir_tab[11] = '{16'd3110, 10'd1023, 14'd2000, 16'd3200, 1'b0, '0};
      // stale well data
      dir_tab[12] = '{16'd3120, 10'd100, 14'd0, 16'd3100, 1'b0, '0};
      // time wraps around
      dir_tab[13] = '{16'd65530, 10'd300, 14'd0, 16'd10, 1'b0, '0};
      dir_tab[14] = '{16'd30000, 10'd300, 14'd0, 16'd30010, 1'b0, '0};
      dir_tab[15] = '{16'd30005, 10'd1023, 14'd0, 16'd30010, 1'b0, '0};
      // data that expires exactly now
      dir_tab[16] = '{16'd40000, 10'd206, 14'd0, 16'd40000, 1'b0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_tick(dir_tab[i].now_time, dir_tab[i].scale_raw, dir_tab[i].well_depth,
                   dir_tab[i].well_valid_until, dir_tab[i].known, dir_tab[i].status);

      plant_now = 16'd0;
      plant_raw = 300;
      plant_depth = 800;
      raw_up = 1'b1;
      depth_up = 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // hold requests until the block has drained
         req_valid <= 1'b0;
         while (awaited_status.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);

         case (ph)
            0: cfg_vals = '{50000, 10000, 0, 50000, 10000, 0, 65535};
            1: cfg_vals = '{0, 0, 0, 0, 0, 0, 0};
            2: cfg_vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            4: cfg_vals = '{$urandom_range(10000, 30000), $urandom_range(0, 3000),
                            $urandom_range(30001, 50000), $urandom_range(0, 20000),
                            $urandom_range(0, 10000), $urandom_range(0, 10000),
                            $urandom_range(0, 2000)};
            5: cfg_vals = '{$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom};
            default: cfg_vals = '{$urandom_range(20000, 50000), $urandom_range(0, 3000),
                                  $urandom_range(1000, 15000), $urandom_range(0, 20000),
                                  $urandom_range(0, 10000), $urandom_range(0, 10000),
                                  (ph == 6) ? $urandom_range(0, 50) : $urandom_range(0, 2000)};
         endcase
         for (int r = 0; r < 7; r++)
            csr_write(tfp_reg_type'(r), cfg_vals[r]);
         csr_write(REG_UNUSED, $urandom);

         quiet = (ph == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) == 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (awaited_status.size() != 0) @(posedge clock);
            end

            if ($urandom_range(0, 99) < 12) begin
               t_now = 16'($urandom);
               t_raw = 10'($urandom);
               t_depth = 14'($urandom);
               t_valid = 16'($urandom);
            end else begin
               // advance a plausible plant: time moves on, level and depth drift
               pick = $urandom_range(0, 99);
               if (pick < 80)
                  plant_now = plant_now + 16'($urandom_range(1, 40));
               else if (pick < 97)
                  plant_now = plant_now + 16'($urandom_range(41, 3000));
               else
                  plant_now = plant_now + 16'($urandom_range(3001, 65535));

               if ($urandom_range(0, 49) == 0) raw_up = !raw_up;
               step = $urandom_range(0, 30);
               plant_raw = raw_up ? plant_raw + step : plant_raw - step;
               if (plant_raw >= RAW_TOP) begin
                  plant_raw = RAW_TOP;
                  raw_up = 1'b0;
               end else if (plant_raw <= 0) begin
                  plant_raw = 0;
                  raw_up = 1'b1;
               end

               if ($urandom_range(0, 19) == 0) begin
                  plant_depth = $urandom_range(0, 12000);
               end else begin
                  if ($urandom_range(0, 39) == 0) depth_up = !depth_up;
                  step = $urandom_range(0, 150);
                  plant_depth = depth_up ? plant_depth + step : plant_depth - step;
                  if (plant_depth >= 12000) begin
                     plant_depth = 12000;
                     depth_up = 1'b0;
                  end else if (plant_depth <= 0) begin
                     plant_depth = 0;
                     depth_up = 1'b1;
                  end
               end

               t_now = plant_now;
               t_raw = 10'(plant_raw);
               t_depth = 14'(plant_depth);
               if ($urandom_range(0, 99) < 88)
                  t_valid = plant_now + 16'($urandom_range(1, 600));
               else
                  t_valid = plant_now - 16'($urandom_range(0, 200));
            end
            send_tick(t_now, t_raw, t_depth, t_valid, 1'b0, '0);
         end
      end

      quiet = 1'b0;
      req_valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_status.size() == 0)
         $display("tb_tank_fill_and_pump_controller_core OK");
      else
         $display("tb_tank_fill_and_pump_controller_core NOT OK");
      $finish;
   end

endmodule
